/* src/lcp_pkg.sv */
// lcp_pkg: shared constants for the lru cache tag store with next-line prefetch
// no dependencies; used by the interfaces and by lru_cache_with_next_line_prefetch
package lcp_pkg;

  localparam int ADDR_W  = 32;
  localparam int LAT_W   = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 10;

  // opcodes of an input beat
  localparam logic OP_READ = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PF_EN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MISS_PEN  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PF_PEN    = 2'd3;

  // reset values of the configuration registers
  localparam logic [LAT_W-1:0] MISS_PEN_RST = 10'd20;
  localparam logic [LAT_W-1:0] PF_PEN_RST   = 10'd20;

endpackage

/* src/lcp_if.sv */
// lcp_if: valid/ready channel interfaces for request and result beats
// depends on lcp_pkg
interface lcp_in_if
  import lcp_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface lcp_out_if
  import lcp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             hit;
  logic [LAT_W-1:0] latency;
  logic             was_prefetched;

  modport source (output valid, output hit, output latency, output was_prefetched,
                  input ready);
  modport sink   (input valid, input hit, input latency, input was_prefetched,
                  output ready);
endinterface

/* src/lcp_ram.sv */
// lcp_ram: generic single write port, single read port ram with registered read
// no dependencies
module lcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not reading
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end
endmodule

/* src/lru_cache_with_next_line_prefetch.sv */
// lru_cache_with_next_line_prefetch: top level of the cache tag store
// depends on lcp_pkg, lcp_if (lcp_in_if, lcp_out_if) and lcp_ram
//
// usage
//   in_chan carries request beats: opcode read (with a byte address) or tick. out_chan
//   returns one result beat per read (hit, latency, was_prefetched); a tick returns nothing.
//   cfg_we/cfg_index/cfg_data write the four registers (cache enable, prefetch enable, miss
//   penalty, prefetch penalty); the user does so only while idle; the block does not enforce it.
// timing
//   one set row (all ways) is kept per ram word; one lookup/update unit serves
//   the demand set and then the prefetch set, one ram read each. read, cache on:
//   demand row read, then lookup and update with a ram write; when a prefetch
//   probe is made, the next set's row is read and looked up, and written on a miss.
//   tick, cache on: all rows, one row per cycle through the shared decrement unit.
//   in_chan.ready is high only while the sequencer is idle.
// reset
//   valid bits of all lines clear at once; registers take their reset values.
// stall
//   a result waits in the output register; the next beat is taken meanwhile,
//   and its own result is held back until the receiver takes the earlier one.
module lru_cache_with_next_line_prefetch
  import lcp_pkg::*;
#(
  parameter int SETS        = 64,
  parameter int WAYS        = 4,
  parameter int BLOCK_BYTES = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  lcp_in_if.sink                in_chan,
  lcp_out_if.source             out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  // address split
  localparam int BW     = $clog2(BLOCK_BYTES + 1) - 1;
  localparam int IW     = $clog2(SETS + 1) - 1;
  localparam int SW     = (IW > 0) ? IW : 1;
  localparam int NSETS  = 1 << IW;
  localparam int TAG_W  = ADDR_W - BW - IW;
  localparam int AGE_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WI_W   = AGE_W;
  // row layout: per way {tag, remaining, prefetched, age}
  localparam int PF_O   = AGE_W;
  localparam int REM_O  = AGE_W + 1;
  localparam int TAG_O  = AGE_W + 1 + LAT_W;
  localparam int WAY_W  = TAG_O + TAG_W;
  localparam int ROW_W  = WAYS * WAY_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIS, S_DLOOK, S_PRD, S_PLOOK, S_TICK
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic             cache_en_r, pf_en_r;
  logic [LAT_W-1:0] miss_pen_r, pf_pen_r;

  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SW-1:0]     idx_r, idx_nxt;
  logic [WAYS-1:0]   valid_r [NSETS];

  logic             out_valid_r, out_valid_nxt;
  logic             hit_r, hit_nxt;
  logic [LAT_W-1:0] lat_r, lat_nxt;
  logic             wpf_r, wpf_nxt;

  // ram ports
  logic             ram_we, ram_re;
  logic [SW-1:0]    ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  lcp_ram #(.WIDTH(ROW_W), .DEPTH(NSETS)) u_row_ram (
    .clk   (clk),
    .wr_en (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .rd_en (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // set and tag of an address
  function automatic logic [SW-1:0] set_of(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] sh;
    sh = a >> BW;
    set_of = (IW == 0) ? '0 : sh[SW-1:0];
  endfunction

  function automatic logic [TAG_W-1:0] tag_of(input logic [ADDR_W-1:0] a);
    logic [ADDR_W-1:0] sh;
    sh = a >> (BW + IW);
    tag_of = sh[TAG_W-1:0];
  endfunction

  logic [ADDR_W-1:0] next_addr;
  logic [SW-1:0]     dset, nset, cur_set;
  logic [TAG_W-1:0]  cur_tag;
  logic              pf_phase;
  logic              in_acc;

  assign next_addr = addr_r + ADDR_W'(BLOCK_BYTES);
  assign dset      = set_of(addr_r);
  assign nset      = set_of(next_addr);
  assign pf_phase  = (state_r == S_PLOOK);
  assign cur_set   = pf_phase ? nset : dset;
  assign cur_tag   = pf_phase ? tag_of(next_addr) : tag_of(addr_r);
  assign in_acc    = in_chan.valid && in_chan.ready;

  // shared lookup and update unit over one set row
  logic [WAYS-1:0]  vld;
  logic             found;
  logic [WI_W-1:0]  hit_way, vict_way, sel;
  logic             was_valid;
  logic [AGE_W-1:0] old_age;
  logic [ROW_W-1:0] upd_row, tick_row;
  logic [WAYS-1:0]  upd_valid;
  logic [LAT_W-1:0] hit_rem;
  logic             hit_pf;

  assign vld = valid_r[cur_set];

  always_comb begin
    logic             inv_found, old_found;
    logic [AGE_W-1:0] a;
    logic [LAT_W-1:0] r;
    found     = 1'b0;
    hit_way   = '0;
    inv_found = 1'b0;
    old_found = 1'b0;
    vict_way  = '0;
    // tag match, first invalid way, oldest way
    for (int w = 0; w < WAYS; w++) begin
      if (!found && vld[w] &&
          ram_rdata[w*WAY_W+TAG_O +: TAG_W] == cur_tag) begin
        found   = 1'b1;
        hit_way = WI_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!inv_found && !vld[w]) begin
        inv_found = 1'b1;
        vict_way  = WI_W'(w);
      end
    end
    for (int w = 0; w < WAYS; w++) begin
      if (!inv_found && !old_found &&
          ram_rdata[w*WAY_W +: AGE_W] == AGE_W'(WAYS - 1)) begin
        old_found = 1'b1;
        vict_way  = WI_W'(w);
      end
    end
    sel       = found ? hit_way : vict_way;
    was_valid = found ? 1'b1 : vld[sel];
    old_age   = ram_rdata[sel*WAY_W +: AGE_W];
    hit_rem   = ram_rdata[hit_way*WAY_W+REM_O +: LAT_W];
    hit_pf    = ram_rdata[hit_way*WAY_W+PF_O];
    upd_valid = vld;
    upd_valid[sel] = 1'b1;
    // age update and line fill or prefetch mark clear
    upd_row = ram_rdata;
    for (int w = 0; w < WAYS; w++) begin
      a = ram_rdata[w*WAY_W +: AGE_W];
      if (WI_W'(w) == sel) begin
        upd_row[w*WAY_W +: AGE_W] = '0;
        upd_row[w*WAY_W+PF_O]     = pf_phase && !found;
        if (!found) begin
          upd_row[w*WAY_W+REM_O +: LAT_W] = pf_phase ? pf_pen_r : miss_pen_r;
          upd_row[w*WAY_W+TAG_O +: TAG_W] = cur_tag;
        end
      end else if (vld[w] && (!was_valid || a < old_age)) begin
        upd_row[w*WAY_W +: AGE_W] = a + AGE_W'(1);
      end
    end
    // saturating countdown of a whole row
    tick_row = ram_rdata;
    for (int w = 0; w < WAYS; w++) begin
      r = ram_rdata[w*WAY_W+REM_O +: LAT_W];
      if (r != '0) begin
        tick_row[w*WAY_W+REM_O +: LAT_W] = r - LAT_W'(1);
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_r || out_chan.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    hit_nxt       = hit_r;
    lat_nxt       = lat_r;
    wpf_nxt       = wpf_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = cur_set;
    ram_raddr     = set_of(in_chan.address);
    ram_wdata     = upd_row;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          addr_nxt = in_chan.address;
          idx_nxt  = '0;
          if (in_chan.opcode == OP_TICK) begin
            if (cache_en_r) begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              state_nxt = S_TICK;
            end
          end else if (cache_en_r) begin
            ram_re    = 1'b1;
            state_nxt = S_DLOOK;
          end else begin
            state_nxt = S_DIS;
          end
        end
      end
      S_DIS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          hit_nxt       = 1'b1;
          lat_nxt       = '0;
          wpf_nxt       = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_DLOOK: begin
        if (out_free) begin
          ram_we        = 1'b1;
          out_valid_nxt = 1'b1;
          hit_nxt       = found;
          lat_nxt       = found ? hit_rem : miss_pen_r;
          wpf_nxt       = found && hit_pf;
          state_nxt     = (pf_en_r && (!found || hit_pf)) ? S_PRD : S_IDLE;
        end
      end
      S_PRD: begin
        ram_re    = 1'b1;
        ram_raddr = nset;
        state_nxt = S_PLOOK;
      end
      S_PLOOK: begin
        ram_we    = !found;
        state_nxt = S_IDLE;
      end
      S_TICK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = tick_row;
        if (idx_r == SW'(NSETS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r + SW'(1);
          idx_nxt   = idx_r + SW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, valid bits, result register and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cache_en_r  <= 1'b1;
      pf_en_r     <= 1'b0;
      miss_pen_r  <= MISS_PEN_RST;
      pf_pen_r    <= PF_PEN_RST;
      for (int s = 0; s < NSETS; s++) begin
        valid_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we && state_r != S_TICK) begin
        valid_r[cur_set] <= upd_valid;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_CACHE_EN: cache_en_r <= cfg_data[0];
          CFG_PF_EN:    pf_en_r    <= cfg_data[0];
          CFG_MISS_PEN: miss_pen_r <= cfg_data[LAT_W-1:0];
          CFG_PF_PEN:   pf_pen_r   <= cfg_data[LAT_W-1:0];
          default: ;
        endcase
      end
    end
    addr_r <= addr_nxt;
    idx_r  <= idx_nxt;
    hit_r  <= hit_nxt;
    lat_r  <= lat_nxt;
    wpf_r  <= wpf_nxt;
  end

  assign in_chan.ready           = (state_r == S_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.hit            = hit_r;
  assign out_chan.latency        = lat_r;
  assign out_chan.was_prefetched = wpf_r;

endmodule
